### design/bdc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bdc_pkg
// shared widths, codes and types of the 3d de casteljau bezier evaluator
// ---------------------------------------------------------------------------
package bdc_pkg;

  localparam int MAX_POINTS = 8;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int COORD_W    = 32;
  localparam int T_W        = 17;
  localparam int FRAC_W     = 16;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 3;

  localparam logic [T_W-1:0] ONE_Q16 = T_W'(65536);

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL  = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    STAT_POS_OK    = 3'd0,
    STAT_STORED    = 3'd1,
    STAT_DROPPED   = 3'd2,
    STAT_NO_POINTS = 3'd3,
    STAT_CLEARED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_DRAIN,
    ST_FINAL_RD,
    ST_FINAL_WAIT,
    ST_EMIT
  } state_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

endpackage
`default_nettype wire

### design/bdc_ifs.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bdc channel interfaces
// command channel (opcode, point, parameter) and result channel
// ---------------------------------------------------------------------------
interface bdc_cmd_if;
  import bdc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           opcode;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic [T_W-1:0]            param_t;

  modport source (output valid, opcode, coord_x, coord_y, coord_z, param_t, input ready);
  modport sink   (input valid, opcode, coord_x, coord_y, coord_z, param_t, output ready);
endinterface

interface bdc_res_if;
  import bdc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic [STAT_W-1:0]         status;

  modport source (output valid, pos_x, pos_y, pos_z, status, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, status, output ready);
endinterface
`default_nettype wire

### design/bdc_lerp_lane.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bdc_lerp_lane
// pipelined fixed point interpolation a + round(t * (b - a)) for one axis
// ---------------------------------------------------------------------------
module bdc_lerp_lane (
  input  wire logic            clk,
  input  wire bdc_pkg::coord_t a,
  input  wire bdc_pkg::coord_t b,
  input  wire logic [bdc_pkg::T_W-1:0] t,
  output bdc_pkg::coord_t      q
);
  import bdc_pkg::*;

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = T_W + 1 + DIFF_W;
  localparam int SUM_W  = PROD_W - FRAC_W;

  logic signed [DIFF_W-1:0] d1;
  coord_t                   a1;
  logic signed [PROD_W-1:0] p2;
  coord_t                   a2;
  logic [SUM_W-1:0]         sum;

  // stage 1: difference
  always_ff @(posedge clk) begin
    d1 <= DIFF_W'(b) - DIFF_W'(a);
    a1 <= a;
  end

  // stage 2: product with t, t is at most one so it fits 18 signed bits
  always_ff @(posedge clk) begin
    p2 <= $signed({1'b0, t}) * d1;
    a2 <= a1;
  end

  // round half up: (p + half) >>> 16 == (p >>> 16) + p[15]
  always_comb begin
    sum = SUM_W'(a2) + p2[PROD_W-1:FRAC_W] + SUM_W'(p2[FRAC_W-1]);
  end

  assign q = sum[COORD_W-1:0];

endmodule
`default_nettype wire

### design/bezier_3d_de_casteljau_eval_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bezier_3d_de_casteljau_eval_unit
// 3d bezier evaluation by de casteljau over a stored table of control points
// ---------------------------------------------------------------------------
// Control points (signed Q16.16) live in a point memory of MAX_POINTS words;
// De Casteljau levels stream through a scratch memory with one read and one
// write port, and three interpolation lanes (x, y, z) work side by side.
// One command transaction is taken at a time and yields one result
// transaction; the next command is taken while a result still waits.
// Each level of an evaluation reads its entries one per cycle from the single
// read port, then waits for the three-stage read and interpolation pipeline
// to drain before the next level reads what it wrote.
// ---------------------------------------------------------------------------
module bezier_3d_de_casteljau_eval_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  bdc_cmd_if.sink    cmd,
  bdc_res_if.source  res
);
  import bdc_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic             out_valid;

  logic [IDX_W-1:0] m;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] rd_addr;
  logic             from_pts;
  logic [T_W-1:0]   t_reg;

  point_t           pts_mem [MAX_POINTS];
  point_t           scr_mem [MAX_POINTS];
  point_t           pts_rd;
  point_t           scr_rd;
  point_t           rd_data;
  point_t           prev;
  point_t           lerp_q;

  logic             s1_valid, s2_valid, s3_valid;
  logic             s1_first;
  logic [IDX_W-1:0] s1_widx, s2_widx, s3_widx;
  logic             busy;

  point_t           res_pt;
  status_t          res_stat;
  point_t           out_pt;
  status_t          out_stat;

  logic             cmd_fire;
  logic             issue;
  logic             final_cap;
  logic             out_load;
  logic             is_eval;
  logic             has_room;

  assign cmd_fire = cmd.valid && cmd.ready;
  assign is_eval  = (cmd.opcode != OP_CLEAR) && (cmd.opcode != OP_ADD);
  assign has_room = count < CNT_W'(MAX_POINTS);
  assign busy     = s1_valid || s2_valid || s3_valid;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          if (!is_eval || count == '0) begin
            state_next = ST_EMIT;
          end else if (count == CNT_W'(1)) begin
            state_next = ST_FINAL_RD;
          end else begin
            state_next = ST_LEVEL;
          end
        end
      end
      ST_LEVEL: begin
        if (rd_idx == m) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!busy) begin
          state_next = (m == IDX_W'(1)) ? ST_FINAL_RD : ST_LEVEL;
        end
      end
      ST_FINAL_RD:   state_next = ST_FINAL_WAIT;
      ST_FINAL_WAIT: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd.ready = 1'b0;
    issue     = 1'b0;
    final_cap = 1'b0;
    out_load  = 1'b0;
    rd_addr   = '0;
    case (state)
      ST_IDLE:       cmd.ready = 1'b1;
      ST_LEVEL: begin
        issue   = 1'b1;
        rd_addr = rd_idx;
      end
      ST_FINAL_WAIT: final_cap = 1'b1;
      ST_EMIT:       out_load = !out_valid || res.ready;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= issue;
      s2_valid <= s1_valid && !s1_first;
      s3_valid <= s2_valid;
      if (cmd_fire) begin
        if (cmd.opcode == OP_CLEAR) begin
          count <= '0;
        end else if (cmd.opcode == OP_ADD && has_room) begin
          count <= count + CNT_W'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sequencing and result registers
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      res_pt   <= '0;
      t_reg    <= (cmd.param_t > ONE_Q16) ? ONE_Q16 : cmd.param_t;
      m        <= IDX_W'(count - CNT_W'(1));
      rd_idx   <= '0;
      from_pts <= 1'b1;
      if (cmd.opcode == OP_CLEAR) begin
        res_stat <= STAT_CLEARED;
      end else if (cmd.opcode == OP_ADD) begin
        res_stat <= has_room ? STAT_STORED : STAT_DROPPED;
      end else if (count == '0) begin
        res_stat <= STAT_NO_POINTS;
      end else begin
        res_stat <= STAT_POS_OK;
      end
    end
    if (issue) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
    if (state == ST_DRAIN && !busy) begin
      m        <= m - IDX_W'(1);
      rd_idx   <= '0;
      from_pts <= 1'b0;
    end
    if (final_cap) begin
      res_pt <= rd_data;
    end
    if (out_load) begin
      out_pt   <= res_pt;
      out_stat <= res_stat;
    end
  end

  // point memory: written on add, read while streaming the first level or, with one point, for the final read
  always_ff @(posedge clk) begin
    if (cmd_fire && cmd.opcode == OP_ADD && has_room) begin
      pts_mem[count[IDX_W-1:0]] <= '{x: cmd.coord_x, y: cmd.coord_y, z: cmd.coord_z};
    end
    pts_rd <= pts_mem[rd_addr];
  end

  // scratch memory: each level writes entry j from entries j and j+1
  always_ff @(posedge clk) begin
    if (s3_valid) begin
      scr_mem[s3_widx] <= lerp_q;
    end
    scr_rd <= scr_mem[rd_addr];
  end

  assign rd_data = from_pts ? pts_rd : scr_rd;

  // pipeline bookkeeping, the first read of a level only primes prev
  always_ff @(posedge clk) begin
    s1_first <= (rd_idx == '0);
    s1_widx  <= rd_idx - IDX_W'(1);
    s2_widx  <= s1_widx;
    s3_widx  <= s2_widx;
    if (s1_valid) begin
      prev <= rd_data;
    end
  end

  bdc_lerp_lane u_lane_x (.clk(clk), .a(prev.x), .b(rd_data.x), .t(t_reg), .q(lerp_q.x));
  bdc_lerp_lane u_lane_y (.clk(clk), .a(prev.y), .b(rd_data.y), .t(t_reg), .q(lerp_q.y));
  bdc_lerp_lane u_lane_z (.clk(clk), .a(prev.z), .b(rd_data.z), .t(t_reg), .q(lerp_q.z));

  assign res.valid  = out_valid;
  assign res.pos_x  = out_pt.x;
  assign res.pos_y  = out_pt.y;
  assign res.pos_z  = out_pt.z;
  assign res.status = out_stat;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count above table size");

  a_add_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && cmd.opcode == OP_ADD && has_room) |=> count == $past(count) + CNT_W'(1))
    else $error("stored point not counted");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && cmd.opcode == OP_CLEAR) |=> count == '0)
    else $error("clear left points in the table");

  a_write_in_eval: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (state == ST_LEVEL || state == ST_DRAIN))
    else $error("scratch write outside evaluation");

  a_final_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL_RD) |-> !busy)
    else $error("final read while interpolation pipeline busy");

endmodule
`default_nettype wire
